>>> hw/rtl/yuvrgb_pkg.sv
// ----------------------------------------------------------------------------
// yuvrgb_pkg
// Shared types and constants for the YUV to RGB pixel converter.
// ----------------------------------------------------------------------------
package yuvrgb_pkg;

    localparam int SAMPLE_W   = 8;
    localparam int POS_W      = 12;
    localparam int COEF_W     = 12;
    localparam int FRAC_BITS  = 10;
    localparam int ADDR_W     = 26;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    // Q.10 sums span about +/-1.3M, so 23 signed bits hold them all
    localparam int SUM_W      = 23;

    localparam logic [SAMPLE_W-1:0] CHROMA_MID = 8'd128;
    localparam logic [SAMPLE_W-1:0] PIX_MAX    = 8'd255;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_COEF_RED_FIRST    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_GREEN_SECOND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_GREEN_FIRST  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_BLUE_SECOND  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT      = 3'd5;

    localparam logic [COEF_W-1:0] COEF_RED_FIRST_RST    = 12'd1404;
    localparam logic [COEF_W-1:0] COEF_GREEN_SECOND_RST = 12'd715;
    localparam logic [COEF_W-1:0] COEF_GREEN_FIRST_RST  = 12'd720;
    localparam logic [COEF_W-1:0] COEF_BLUE_SECOND_RST  = 12'd1774;
    localparam int FRAME_WIDTH_RST  = 352;
    localparam int FRAME_HEIGHT_RST = 288;

    typedef struct packed {
        logic [SAMPLE_W-1:0] luma;
        logic [SAMPLE_W-1:0] chroma_first;
        logic [SAMPLE_W-1:0] chroma_second;
        logic [POS_W-1:0]    column;
        logic [POS_W-1:0]    row;
    } pixel_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] red;
        logic [SAMPLE_W-1:0] green;
        logic [SAMPLE_W-1:0] blue;
        logic [ADDR_W-1:0]   byte_address;
        logic                out_of_frame;
    } result_t;

    typedef struct packed {
        logic [COEF_W-1:0] red_first;
        logic [COEF_W-1:0] green_second;
        logic [COEF_W-1:0] green_first;
        logic [COEF_W-1:0] blue_second;
    } coef_set_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] red;
        logic [SAMPLE_W-1:0] green;
        logic [SAMPLE_W-1:0] blue;
    } rgb_t;

endpackage

>>> hw/rtl/yuvrgb_cfg.sv
// ----------------------------------------------------------------------------
// yuvrgb_cfg
// Configuration registers: color gains and frame size, the size saturated on write.
// ----------------------------------------------------------------------------
module yuvrgb_cfg #(
    parameter int MAX_DIM = 4096,
    parameter int DIM_W   = 13
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    input  logic [yuvrgb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [yuvrgb_pkg::CFG_DATA_W-1:0]  cfg_data,
    output yuvrgb_pkg::coef_set_t              coefs,
    output logic [DIM_W-1:0]                   frame_w,
    output logic [DIM_W-1:0]                   frame_h
);

    localparam int SAT_W = (DIM_W > yuvrgb_pkg::CFG_DATA_W) ? DIM_W
                                                              : yuvrgb_pkg::CFG_DATA_W;
    localparam logic [DIM_W-1:0] W_RST = DIM_W'((yuvrgb_pkg::FRAME_WIDTH_RST > MAX_DIM)
                                         ? MAX_DIM : yuvrgb_pkg::FRAME_WIDTH_RST);
    localparam logic [DIM_W-1:0] H_RST = DIM_W'((yuvrgb_pkg::FRAME_HEIGHT_RST > MAX_DIM)
                                         ? MAX_DIM : yuvrgb_pkg::FRAME_HEIGHT_RST);

    yuvrgb_pkg::coef_set_t coefs_reg;
    logic [DIM_W-1:0]      frame_w_reg;
    logic [DIM_W-1:0]      frame_h_reg;
    logic [SAT_W-1:0]      data_x;
    logic [DIM_W-1:0]      dim_sat;
    logic [yuvrgb_pkg::COEF_W-1:0] coef_val;

    // Clip frame size to the largest supported dimension
    assign data_x   = SAT_W'(cfg_data);
    assign dim_sat  = (data_x > SAT_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(data_x);
    assign coef_val = cfg_data[yuvrgb_pkg::COEF_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coefs_reg.red_first    <= yuvrgb_pkg::COEF_RED_FIRST_RST;
            coefs_reg.green_second <= yuvrgb_pkg::COEF_GREEN_SECOND_RST;
            coefs_reg.green_first  <= yuvrgb_pkg::COEF_GREEN_FIRST_RST;
            coefs_reg.blue_second  <= yuvrgb_pkg::COEF_BLUE_SECOND_RST;
            frame_w_reg            <= W_RST;
            frame_h_reg            <= H_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                yuvrgb_pkg::REG_COEF_RED_FIRST:    coefs_reg.red_first    <= coef_val;
                yuvrgb_pkg::REG_COEF_GREEN_SECOND: coefs_reg.green_second <= coef_val;
                yuvrgb_pkg::REG_COEF_GREEN_FIRST:  coefs_reg.green_first  <= coef_val;
                yuvrgb_pkg::REG_COEF_BLUE_SECOND:  coefs_reg.blue_second  <= coef_val;
                yuvrgb_pkg::REG_FRAME_WIDTH:       frame_w_reg            <= dim_sat;
                yuvrgb_pkg::REG_FRAME_HEIGHT:      frame_h_reg            <= dim_sat;
                default:                           ; // drop writes to unknown indexes
            endcase
        end
    end

    assign coefs   = coefs_reg;
    assign frame_w = frame_w_reg;
    assign frame_h = frame_h_reg;

endmodule

>>> hw/rtl/yuvrgb_color.sv
// ----------------------------------------------------------------------------
// yuvrgb_color
// Q.10 color matrix with truncation toward zero and clamping to 0..255.
// ----------------------------------------------------------------------------
module yuvrgb_color (
    input  logic [yuvrgb_pkg::SAMPLE_W-1:0] luma,
    input  logic [yuvrgb_pkg::SAMPLE_W-1:0] chroma_first,
    input  logic [yuvrgb_pkg::SAMPLE_W-1:0] chroma_second,
    input  yuvrgb_pkg::coef_set_t           coefs,
    output yuvrgb_pkg::rgb_t                rgb
);

    localparam int SW = yuvrgb_pkg::SUM_W;

    logic signed [SW-1:0] ybase;
    logic signed [SW-1:0] d1;
    logic signed [SW-1:0] d2;
    logic signed [SW-1:0] k_rf;
    logic signed [SW-1:0] k_gs;
    logic signed [SW-1:0] k_gf;
    logic signed [SW-1:0] k_bs;
    logic signed [SW-1:0] sum_r;
    logic signed [SW-1:0] sum_g;
    logic signed [SW-1:0] sum_b;

    function automatic logic [yuvrgb_pkg::SAMPLE_W-1:0] clamp_q10(
        input logic signed [SW-1:0] s
    );
        logic [SW-1:0] v;
        begin
            v = SW'(s) >> yuvrgb_pkg::FRAC_BITS;
            if (s < 0)
                clamp_q10 = '0;
            else if (v > SW'(yuvrgb_pkg::PIX_MAX))
                clamp_q10 = yuvrgb_pkg::PIX_MAX;
            else
                clamp_q10 = v[yuvrgb_pkg::SAMPLE_W-1:0];
        end
    endfunction

    assign ybase = $signed(SW'(luma) << yuvrgb_pkg::FRAC_BITS);
    assign d1    = $signed(SW'(chroma_first)) - $signed(SW'(yuvrgb_pkg::CHROMA_MID));
    assign d2    = $signed(SW'(chroma_second)) - $signed(SW'(yuvrgb_pkg::CHROMA_MID));
    assign k_rf  = $signed(SW'(coefs.red_first));
    assign k_gs  = $signed(SW'(coefs.green_second));
    assign k_gf  = $signed(SW'(coefs.green_first));
    assign k_bs  = $signed(SW'(coefs.blue_second));

    assign sum_r = ybase + k_rf * d1;
    assign sum_g = ybase - k_gs * d2 - k_gf * d1;
    assign sum_b = ybase + k_bs * d2;

    assign rgb.red   = clamp_q10(sum_r);
    assign rgb.green = clamp_q10(sum_g);
    assign rgb.blue  = clamp_q10(sum_b);

endmodule

>>> hw/rtl/yuvrgb_addr.sv
// ----------------------------------------------------------------------------
// yuvrgb_addr
// Bottom-up 24-bit bitmap byte address and frame bounds check.
// ----------------------------------------------------------------------------
module yuvrgb_addr #(
    parameter int DIM_W = 13
) (
    input  logic [yuvrgb_pkg::POS_W-1:0]  column,
    input  logic [yuvrgb_pkg::POS_W-1:0]  row,
    input  logic [DIM_W-1:0]              frame_w,
    input  logic [DIM_W-1:0]              frame_h,
    output logic [yuvrgb_pkg::ADDR_W-1:0] byte_address,
    output logic                          out_of_frame
);

    localparam int CALC_W = (2 * DIM_W + 2 > yuvrgb_pkg::ADDR_W) ? 2 * DIM_W + 2
                                                                 : yuvrgb_pkg::ADDR_W;

    logic [CALC_W-1:0] col_x;
    logic [CALC_W-1:0] row_x;
    logic [CALC_W-1:0] w_x;
    logic [CALC_W-1:0] h_x;
    logic [CALC_W-1:0] line;
    logic [CALC_W-1:0] pix_index;
    logic [CALC_W-1:0] offset;

    assign col_x = CALC_W'(column);
    assign row_x = CALC_W'(row);
    assign w_x   = CALC_W'(frame_w);
    assign h_x   = CALC_W'(frame_h);

    assign out_of_frame = (col_x >= w_x) || (row_x >= h_x);

    // Rows are stored last line first
    assign line      = h_x - CALC_W'(1) - row_x;
    assign pix_index = line * w_x + col_x;
    assign offset    = (pix_index << 1) + pix_index;

    assign byte_address = out_of_frame ? '0 : offset[yuvrgb_pkg::ADDR_W-1:0];

endmodule

>>> hw/rtl/yuv_to_rgb_bottom_up_pixel.sv
// ----------------------------------------------------------------------------
// yuv_to_rgb_bottom_up_pixel
// YUV 4:2:0 pixel to RGB24 converter with bottom-up bitmap addressing.
// ----------------------------------------------------------------------------
// Every pixel is held in the input register, then the color matrix and
// the address multiplier settle into the result register. busy stays
// low, so a pixel can be started on every clock
// and results come out at one per clock in start order. The done strobe is
// high for exactly one cycle per pixel and cannot be held off, so the
// receiver must take result whenever done is high. Configuration writes are
// always taken (cfg_ready is high) and must be issued with no pixel in flight.
module yuv_to_rgb_bottom_up_pixel #(
    parameter int MAX_DIM = 4096
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  yuvrgb_pkg::pixel_t                 pixel,
    output logic                               done,
    output yuvrgb_pkg::result_t                result,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [yuvrgb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [yuvrgb_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);

    yuvrgb_pkg::coef_set_t coefs;
    logic [DIM_W-1:0]      frame_w;
    logic [DIM_W-1:0]      frame_h;

    logic                  accept;
    logic                  pix_valid_reg;
    yuvrgb_pkg::pixel_t    pix_reg;
    logic                  done_reg;
    yuvrgb_pkg::result_t   result_reg;
    yuvrgb_pkg::result_t   result_next;
    yuvrgb_pkg::rgb_t      rgb;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    yuvrgb_cfg #(
        .MAX_DIM (MAX_DIM),
        .DIM_W   (DIM_W)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coefs     (coefs),
        .frame_w   (frame_w),
        .frame_h   (frame_h)
    );

    yuvrgb_color u_color (
        .luma          (pix_reg.luma),
        .chroma_first  (pix_reg.chroma_first),
        .chroma_second (pix_reg.chroma_second),
        .coefs         (coefs),
        .rgb           (rgb)
    );

    yuvrgb_addr #(
        .DIM_W (DIM_W)
    ) u_addr (
        .column       (pix_reg.column),
        .row          (pix_reg.row),
        .frame_w      (frame_w),
        .frame_h      (frame_h),
        .byte_address (result_next.byte_address),
        .out_of_frame (result_next.out_of_frame)
    );

    assign result_next.red   = rgb.red;
    assign result_next.green = rgb.green;
    assign result_next.blue  = rgb.blue;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            pix_valid_reg <= accept;
            done_reg      <= pix_valid_reg;
        end
    end

    // Payload registers: capture on every transaction, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
            pix_reg <= pixel;
        if (pix_valid_reg)
            result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef ASSERT_OFF
    a_start_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##2 done)
        else $error("accepted pixel did not produce a result two cycles later");

    a_no_spurious_done: assert property (@(posedge clk) disable iff (!rst_n)
        !pix_valid_reg |=> !done)
        else $error("done raised without a pixel in the input register");

    a_oof_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.out_of_frame) |-> (result.byte_address == '0))
        else $error("out-of-frame pixel carries a nonzero address");

    a_oof_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_valid_reg && (32'(pix_reg.column) < 32'(frame_w))
         && (32'(pix_reg.row) < 32'(frame_h)))
        |=> !result.out_of_frame)
        else $error("in-frame pixel flagged out of frame");
`endif

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the YUV to RGB pixel converter.
// Drives a short table of hand-picked pixels under the reset configuration,
// then several configuration phases of random pixels, including the extreme
// gains and frame sizes. Each result is checked field by field against a typed
// expectation or an in-bench color matrix and bottom-up address calculation.
// ----------------------------------------------------------------------------
module tb;

    localparam int MAX_FRAME_DIM = 4096;
    localparam int PHASES = 8;
    localparam int PIXELS_PER_PHASE = 150;

    // Indexes the block has no register behind
    localparam logic [yuvrgb_pkg::CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [yuvrgb_pkg::CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    typedef struct {
        yuvrgb_pkg::pixel_t  px;
        bit                  typed;
        yuvrgb_pkg::result_t want;
    } stim_row_t;

    logic                                  clk;
    logic                                  rst_n;
    logic                                  start;
    logic                                  busy;
    yuvrgb_pkg::pixel_t                    pixel;
    logic                                  done;
    yuvrgb_pkg::result_t                   result;
    logic                                  cfg_valid;
    logic                                  cfg_ready;
    logic [yuvrgb_pkg::CFG_IDX_W-1:0]      cfg_index;
    logic [yuvrgb_pkg::CFG_DATA_W-1:0]     cfg_data;

    // Bench copy of the configuration registers
    logic [yuvrgb_pkg::COEF_W-1:0]         gain_r1;
    logic [yuvrgb_pkg::COEF_W-1:0]         gain_g2;
    logic [yuvrgb_pkg::COEF_W-1:0]         gain_g1;
    logic [yuvrgb_pkg::COEF_W-1:0]         gain_b2;
    logic [yuvrgb_pkg::CFG_DATA_W-1:0]     width_set;
    logic [yuvrgb_pkg::CFG_DATA_W-1:0]     height_set;

    // Typed expectation that travels with the pixel on the bus
    logic                                  row_typed;
    yuvrgb_pkg::result_t                   row_expect;

    yuvrgb_pkg::result_t                   expected_pixels[$];
    yuvrgb_pkg::result_t                   oldest;
    stim_row_t                             directed_rows[$];
    bit                                    mismatch_seen;

    yuv_to_rgb_bottom_up_pixel dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .pixel     (pixel),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic int frame_dim(input logic [yuvrgb_pkg::CFG_DATA_W-1:0] d);
        return (d > MAX_FRAME_DIM) ? MAX_FRAME_DIM : int'(d);
    endfunction

    function automatic logic [yuvrgb_pkg::SAMPLE_W-1:0] clamp_component(input longint s);
        longint v;
        if (s < 0)
            return '0;
        v = s >>> yuvrgb_pkg::FRAC_BITS;
        if (v > longint'(yuvrgb_pkg::PIX_MAX))
            return yuvrgb_pkg::PIX_MAX;
        return v[yuvrgb_pkg::SAMPLE_W-1:0];
    endfunction

    function automatic yuvrgb_pkg::result_t convert_pixel(input yuvrgb_pkg::pixel_t px);
        longint              ybase;
        longint              d1;
        longint              d2;
        longint              w_eff;
        longint              h_eff;
        longint              addr_full;
        yuvrgb_pkg::result_t res;
        ybase = longint'(px.luma) <<< yuvrgb_pkg::FRAC_BITS;
        d1 = longint'(px.chroma_first) - longint'(yuvrgb_pkg::CHROMA_MID);
        d2 = longint'(px.chroma_second) - longint'(yuvrgb_pkg::CHROMA_MID);
        res.red = clamp_component(ybase + longint'(gain_r1) * d1);
        res.green = clamp_component(ybase - longint'(gain_g2) * d2 - longint'(gain_g1) * d1);
        res.blue = clamp_component(ybase + longint'(gain_b2) * d2);
        w_eff = frame_dim(width_set);
        h_eff = frame_dim(height_set);
        if (longint'(px.column) >= w_eff || longint'(px.row) >= h_eff) begin
            res.out_of_frame = 1'b1;
            res.byte_address = '0;
        end
        else begin
            // rows are stored bottom-up
            addr_full = ((h_eff - 1 - longint'(px.row)) * w_eff + longint'(px.column)) * 3;
            res.out_of_frame = 1'b0;
            res.byte_address = addr_full[yuvrgb_pkg::ADDR_W-1:0];
        end
        return res;
    endfunction

    function automatic logic [yuvrgb_pkg::SAMPLE_W-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return '0;
        if (r == 1)
            return yuvrgb_pkg::PIX_MAX;
        if (r == 2)
            return yuvrgb_pkg::CHROMA_MID;
        return 8'($urandom_range(0, 255));
    endfunction

    // Mostly inside the frame, with the border and some noise
    function automatic logic [yuvrgb_pkg::POS_W-1:0] pick_position(input int lim);
        int r;
        r = $urandom_range(0, 9);
        if (lim == 0 || r == 9)
            return 12'($urandom_range(0, (1 << yuvrgb_pkg::POS_W) - 1));
        if (r == 8)
            return 12'((lim > (1 << yuvrgb_pkg::POS_W) - 1) ? (1 << yuvrgb_pkg::POS_W) - 1
                                                             : lim);
        if (r == 7)
            return 12'(lim - 1);
        return 12'($urandom_range(0, lim - 1));
    endfunction

    function automatic yuvrgb_pkg::pixel_t random_pixel();
        yuvrgb_pkg::pixel_t px;
        px.luma = pick_sample();
        px.chroma_first = pick_sample();
        px.chroma_second = pick_sample();
        px.column = pick_position(frame_dim(width_set));
        px.row = pick_position(frame_dim(height_set));
        return px;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    task automatic add_row(input logic [7:0] y, input logic [7:0] cf, input logic [7:0] cs,
                           input logic [11:0] col, input logic [11:0] rw, input bit typed,
                           input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                           input logic [25:0] addr, input bit oof);
        stim_row_t s;
        s.px = '{luma: y, chroma_first: cf, chroma_second: cs, column: col, row: rw};
        s.typed = typed;
        s.want = '{red: r, green: g, blue: b, byte_address: addr, out_of_frame: oof};
        directed_rows.push_back(s);
    endtask

    task automatic send_pixel(input yuvrgb_pkg::pixel_t px, input bit typed,
                              input yuvrgb_pkg::result_t want);
        start <= 1'b1;
        pixel <= px;
        row_typed <= typed;
        row_expect <= want;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Idle after a transaction: either a random gap or a full drain
    task automatic pace(input bit pause, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : pick_gap();
        if (pause) begin
            start <= 1'b0;
            @(posedge clk);
            while (expected_pixels.size() != 0)
                @(posedge clk);
        end
        else if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [yuvrgb_pkg::CFG_IDX_W-1:0] idx,
                             input logic [yuvrgb_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            yuvrgb_pkg::REG_COEF_RED_FIRST:    gain_r1 = data[yuvrgb_pkg::COEF_W-1:0];
            yuvrgb_pkg::REG_COEF_GREEN_SECOND: gain_g2 = data[yuvrgb_pkg::COEF_W-1:0];
            yuvrgb_pkg::REG_COEF_GREEN_FIRST:  gain_g1 = data[yuvrgb_pkg::COEF_W-1:0];
            yuvrgb_pkg::REG_COEF_BLUE_SECOND:  gain_b2 = data[yuvrgb_pkg::COEF_W-1:0];
            yuvrgb_pkg::REG_FRAME_WIDTH:       width_set = data;
            yuvrgb_pkg::REG_FRAME_HEIGHT:      height_set = data;
            default: ;
        endcase
    endtask

    task automatic configure_phase(input int ph);
        logic [yuvrgb_pkg::CFG_DATA_W-1:0] vals [6];
        int i;
        for (i = 0; i < 6; i++)
            vals[i] = (i < 4) ? 13'($urandom_range(0, 8191)) : 13'($urandom_range(2, 640));
        case (ph)
            0: begin
                for (i = 0; i < 4; i++)
                    vals[i] = '0;
                vals[4] = 13'd2;
                vals[5] = 13'd2;
            end
            1: begin
                for (i = 0; i < 4; i++)
                    vals[i] = 13'((1 << yuvrgb_pkg::COEF_W) - 1);
                vals[4] = 13'(MAX_FRAME_DIM);
                vals[5] = 13'(MAX_FRAME_DIM);
            end
            2: begin
                // above the maximum: saturates
                vals[4] = 13'd8191;
                vals[5] = 13'd5000;
            end
            3: begin
                vals[0] = {1'b0, yuvrgb_pkg::COEF_RED_FIRST_RST};
                vals[1] = {1'b0, yuvrgb_pkg::COEF_GREEN_SECOND_RST};
                vals[2] = {1'b0, yuvrgb_pkg::COEF_GREEN_FIRST_RST};
                vals[3] = {1'b0, yuvrgb_pkg::COEF_BLUE_SECOND_RST};
                vals[4] = '0;
                vals[5] = 13'd1;
            end
            4: begin
                vals[4] = 13'd1;
                vals[5] = '0;
            end
            5: begin
                vals[4] = 13'($urandom_range(2, MAX_FRAME_DIM));
                vals[5] = 13'($urandom_range(2, MAX_FRAME_DIM));
            end
            6: begin
                vals[4] = 13'($urandom_range(0, 8191));
                vals[5] = 13'($urandom_range(0, 8191));
            end
            default: begin
                vals[4] = 13'(yuvrgb_pkg::FRAME_WIDTH_RST);
                vals[5] = 13'(yuvrgb_pkg::FRAME_HEIGHT_RST);
            end
        endcase
        write_reg(yuvrgb_pkg::REG_COEF_RED_FIRST, vals[0]);
        write_reg(yuvrgb_pkg::REG_COEF_GREEN_SECOND, vals[1]);
        write_reg(yuvrgb_pkg::REG_COEF_GREEN_FIRST, vals[2]);
        write_reg(yuvrgb_pkg::REG_COEF_BLUE_SECOND, vals[3]);
        write_reg(yuvrgb_pkg::REG_FRAME_WIDTH, vals[4]);
        write_reg(yuvrgb_pkg::REG_FRAME_HEIGHT, vals[5]);
        // must be dropped by the block
        write_reg(ph[0] ? REG_SPARE_7 : REG_SPARE_6, 13'($urandom_range(0, 8191)));
        cfg_valid <= 1'b0;
    endtask

    // Predict on every accepted transaction, check on every done strobe
    always @(posedge clk) begin
        if (rst_n) begin
            if (start && !busy)
                expected_pixels.push_back(row_typed ? row_expect : convert_pixel(pixel));
            if (done) begin
                if (expected_pixels.size() == 0) begin
                    $error("result with no pixel pending");
                    mismatch_seen = 1'b1;
                end
                else begin
                    oldest = expected_pixels.pop_front();
                    if (result.red !== oldest.red) begin
                        $error("red: expected %0d, got %0d", oldest.red, result.red);
                        mismatch_seen = 1'b1;
                    end
                    if (result.green !== oldest.green) begin
                        $error("green: expected %0d, got %0d", oldest.green, result.green);
                        mismatch_seen = 1'b1;
                    end
                    if (result.blue !== oldest.blue) begin
                        $error("blue: expected %0d, got %0d", oldest.blue, result.blue);
                        mismatch_seen = 1'b1;
                    end
                    if (result.byte_address !== oldest.byte_address) begin
                        $error("byte_address: expected %0d, got %0d",
                               oldest.byte_address, result.byte_address);
                        mismatch_seen = 1'b1;
                    end
                    if (result.out_of_frame !== oldest.out_of_frame) begin
                        $error("out_of_frame: expected %0d, got %0d",
                               oldest.out_of_frame, result.out_of_frame);
                        mismatch_seen = 1'b1;
                    end
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        int ph;
        int n;
        gain_r1 = yuvrgb_pkg::COEF_RED_FIRST_RST;
        gain_g2 = yuvrgb_pkg::COEF_GREEN_SECOND_RST;
        gain_g1 = yuvrgb_pkg::COEF_GREEN_FIRST_RST;
        gain_b2 = yuvrgb_pkg::COEF_BLUE_SECOND_RST;
        width_set = 13'(yuvrgb_pkg::FRAME_WIDTH_RST);
        height_set = 13'(yuvrgb_pkg::FRAME_HEIGHT_RST);
        rst_n <= 1'b0;
        start <= 1'b0;
        pixel <= '0;
        row_typed <= 1'b0;
        row_expect <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;

        // Reset frame is 352 x 288; neutral chroma passes luma straight through
        add_row(8'd0, 8'd128, 8'd128, 12'd0, 12'd0, 1'b1,
                8'd0, 8'd0, 8'd0, 26'd303072, 1'b0);
        add_row(8'd255, 8'd128, 8'd128, 12'd351, 12'd287, 1'b1,
                8'd255, 8'd255, 8'd255, 26'd1053, 1'b0);
        add_row(8'd0, 8'd128, 8'd128, 12'd0, 12'd287, 1'b1,
                8'd0, 8'd0, 8'd0, 26'd0, 1'b0);
        add_row(8'd50, 8'd128, 8'd128, 12'd351, 12'd0, 1'b1,
                8'd50, 8'd50, 8'd50, 26'd304125, 1'b0);
        add_row(8'd100, 8'd128, 8'd128, 12'd352, 12'd0, 1'b1,
                8'd100, 8'd100, 8'd100, 26'd0, 1'b1);
        add_row(8'd100, 8'd128, 8'd128, 12'd0, 12'd288, 1'b1,
                8'd100, 8'd100, 8'd100, 26'd0, 1'b1);
        add_row(8'd50, 8'd128, 8'd128, 12'd351, 12'd288, 1'b1,
                8'd50, 8'd50, 8'd50, 26'd0, 1'b1);
        add_row(8'd255, 8'd128, 8'd128, 12'd4095, 12'd4095, 1'b1,
                8'd255, 8'd255, 8'd255, 26'd0, 1'b1);
        add_row(8'd0, 8'd255, 8'd0, 12'd10, 12'd10, 1'b0, 8'd0, 8'd0, 8'd0, 26'd0, 1'b0);
        add_row(8'd255, 8'd0, 8'd255, 12'd0, 12'd0, 1'b0, 8'd0, 8'd0, 8'd0, 26'd0, 1'b0);
        add_row(8'd255, 8'd255, 8'd255, 12'd200, 12'd100, 1'b0,
                8'd0, 8'd0, 8'd0, 26'd0, 1'b0);
        add_row(8'd0, 8'd0, 8'd0, 12'd1, 12'd1, 1'b0, 8'd0, 8'd0, 8'd0, 26'd0, 1'b0);
        add_row(8'd128, 8'd255, 8'd128, 12'd5, 12'd6, 1'b0, 8'd0, 8'd0, 8'd0, 26'd0, 1'b0);
        add_row(8'd128, 8'd128, 8'd255, 12'd7, 12'd8, 1'b0, 8'd0, 8'd0, 8'd0, 26'd0, 1'b0);
        add_row(8'd128, 8'd0, 8'd128, 12'd9, 12'd10, 1'b0, 8'd0, 8'd0, 8'd0, 26'd0, 1'b0);
        add_row(8'd128, 8'd128, 8'd0, 12'd11, 12'd12, 1'b0, 8'd0, 8'd0, 8'd0, 26'd0, 1'b0);
        add_row(8'hAA, 8'h55, 8'hAA, 12'hAAA, 12'h155, 1'b0,
                8'd0, 8'd0, 8'd0, 26'd0, 1'b0);
        add_row(8'h55, 8'hAA, 8'h55, 12'h155, 12'h0AA, 1'b0,
                8'd0, 8'd0, 8'd0, 26'd0, 1'b0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i]) begin
            send_pixel(directed_rows[i].px, directed_rows[i].typed, directed_rows[i].want);
            pace(1'b0, 1'b0);
        end

        for (ph = 0; ph < PHASES; ph++) begin
            drain();
            configure_phase(ph);
            for (n = 0; n < PIXELS_PER_PHASE; n++) begin
                send_pixel(random_pixel(), 1'b0, '0);
                // back-to-back stretch, then one full drain mid-phase
                pace(n == 100, n >= 40 && n < 80);
            end
        end

        drain();
        if (!mismatch_seen)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
